@@ sv/tcw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = COLUMNS * ROWS;
    localparam int TAB_STEP = 4;

    // Widths: derived from the geometry, or fixed
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PTR_W  = $clog2(CELLS + 1);
    localparam int COL_W  = $clog2(COLUMNS + TAB_STEP);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int POS_W  = 11;
    localparam int IDX_W  = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = ATTR_W + CHAR_W;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    localparam logic [ATTR_W-1:0] COLOR_RESET = 8'h0F;

    typedef enum logic [1:0] {
        KIND_PUT   = 2'd0,
        KIND_CLEAR = 2'd1,
        KIND_READ  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCROLL,
        ST_FILL,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic              valid;
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
    } res_t;

endpackage

`default_nettype wire

@@ sv/tcw_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ sv/tcw_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        kind,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic [IDX_W-1:0]  cell_index,
    input  wire logic [ATTR_W-1:0] text_color,
    output logic                   ram_we,
    output logic [ADDR_W-1:0]      ram_waddr,
    output logic [CELL_W-1:0]      ram_wdata,
    output logic                   ram_re,
    output logic [ADDR_W-1:0]      ram_raddr,
    input  wire logic [CELL_W-1:0] ram_rdata,
    output res_t                   res,
    input  wire logic              res_ready
);

    localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
    localparam logic [IDX_W:0]    CELLS_X    = (IDX_W + 1)'(CELLS);
    localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(CELLS - 1);
    localparam logic [PTR_W-1:0]  PTR_END    = PTR_W'(CELLS);
    localparam logic [PTR_W-1:0]  PTR_COLS   = PTR_W'(COLUMNS);
    localparam logic [PTR_W-1:0]  PTR_BOTTOM = PTR_W'(CELLS - COLUMNS);
    localparam logic [COL_W-1:0]  TAB_MASK   = ~COL_W'(TAB_STEP - 1);

    state_t              state_reg, state_next;
    logic [PTR_W-1:0]    ptr_reg, ptr_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic                copy_vld_reg, copy_vld_next;
    logic [ADDR_W-1:0]   copy_addr_reg, copy_addr_next;
    logic                read_hit_reg, read_hit_next;

    // put decode
    logic [COL_W-1:0]    put_col;
    logic [ROW_W-1:0]    put_row;
    logic [COL_W-1:0]    put_wcol;
    logic [CHAR_W-1:0]   put_char;
    logic                put_we;
    logic                put_scroll;
    logic [ADDR_W-1:0]   put_addr;
    logic                read_in_range;

    always_comb
    begin
        put_col    = col_reg;
        put_row    = row_reg;
        put_wcol   = col_reg;
        put_char   = char_code;
        put_we     = 1'b0;
        put_scroll = 1'b0;
        case (char_code)
            CH_LF:
            begin
                put_col = '0;
                put_row = row_reg + ROW_W'(1);
            end
            CH_CR:
            begin
                put_col = '0;
            end
            CH_TAB:
            begin
                put_col = (col_reg + COL_W'(TAB_STEP)) & TAB_MASK;
            end
            CH_BS:
            begin
                if (col_reg != '0)
                begin
                    put_col  = col_reg - COL_W'(1);
                    put_wcol = col_reg - COL_W'(1);
                    put_char = CH_BLANK;
                    put_we   = 1'b1;
                end
            end
            default:
            begin
                put_col = col_reg + COL_W'(1);
                put_we  = 1'b1;
            end
        endcase
        // wrap at the row end, scroll at the bottom
        if (put_col >= COL_W'(COLUMNS))
        begin
            put_col = '0;
            put_row = put_row + ROW_W'(1);
        end
        if (put_row >= ROW_W'(ROWS))
        begin
            put_row    = ROW_W'(ROWS - 1);
            put_scroll = 1'b1;
        end
    end

    assign put_addr      = ADDR_W'(row_reg) * COLS_A + ADDR_W'(put_wcol);
    assign read_in_range = {1'b0, cell_index} < CELLS_X;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            ptr_reg      <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            copy_vld_reg <= 1'b0;
            read_hit_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ptr_reg      <= ptr_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            copy_vld_reg <= copy_vld_next;
            read_hit_reg <= read_hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        copy_addr_reg <= copy_addr_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        copy_vld_next  = 1'b0;
        copy_addr_next = copy_addr_reg;
        read_hit_next  = read_hit_reg;
        in_ready       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = ptr_reg[ADDR_W-1:0];
        ram_wdata      = {text_color, CH_BLANK};
        ram_re         = 1'b0;
        ram_raddr      = ptr_reg[ADDR_W-1:0];
        res.valid      = 1'b0;
        res.cursor_pos = POS_W'(ADDR_W'(row_reg) * COLS_A + ADDR_W'(col_reg));
        res.cell_data  = read_hit_reg ? ram_rdata : '0;

        case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {COLOR_RESET, CH_BLANK};
                ptr_next  = ptr_reg + PTR_W'(1);
                if (ptr_reg == PTR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    read_hit_next = 1'b0;
                    state_next    = ST_RESULT;
                    case (kind_t'(kind))
                        KIND_PUT:
                        begin
                            ram_we    = put_we;
                            ram_waddr = put_addr;
                            ram_wdata = {text_color, put_char};
                            col_next  = put_col;
                            row_next  = put_row;
                            if (put_scroll)
                            begin
                                ptr_next   = PTR_COLS;
                                state_next = ST_SCROLL;
                            end
                        end
                        KIND_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            ptr_next   = '0;
                            state_next = ST_FILL;
                        end
                        KIND_READ:
                        begin
                            ram_re        = read_in_range;
                            ram_raddr     = ADDR_W'(cell_index);
                            read_hit_next = read_in_range;
                        end
                        default:
                        begin
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_SCROLL:
            begin
                // write back the cell read last cycle one row higher
                if (copy_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = copy_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (ptr_reg != PTR_END)
                begin
                    ram_re         = 1'b1;
                    copy_vld_next  = 1'b1;
                    copy_addr_next = ADDR_W'(ptr_reg - PTR_COLS);
                    ptr_next       = ptr_reg + PTR_W'(1);
                end
                else
                begin
                    ptr_next   = PTR_BOTTOM;
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                ram_we   = 1'b1;
                ptr_next = ptr_reg + PTR_W'(1);
                if (ptr_reg == PTR_LAST)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                res.valid = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (col_reg < COL_W'(COLUMNS)) && (row_reg < ROW_W'(ROWS)))
        else $error("cursor outside the screen");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ({1'b0, ram_waddr} < (ADDR_W + 1)'(CELLS)))
        else $error("screen write outside the store");

    a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("read and write of the same cell in one cycle");

    a_copy_in_scroll: assert property (@(posedge clk) disable iff (!rst_n)
        copy_vld_reg |-> (state_reg == ST_SCROLL))
        else $error("row copy pending outside a scroll");

endmodule

`default_nettype wire

@@ sv/text_console_writer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Text-mode console: a screen store of COLUMNS x ROWS character/attribute cells
// in one single-port-write, registered-read RAM, plus a cursor. Each request gives
// exactly one result carrying the cursor position and, for reads, the cell.
// Ordinary puts, reads and unused kinds go from idle straight to the result state.
// A clear and a put that scrolls both walk the whole store through the single RAM
// write port, one cell per cycle. After reset a clearing pass over every cell runs
// before the first request is taken; text_color writes are accepted at any time.
// A new request is taken once the previous result sits in the output register.
module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8], zero pad
    input  wire logic [1:0]  s_tuser,   // kind[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // cursor_pos[10:0], cell_data[26:11], zero pad
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data   // text_color
);

    logic [ATTR_W-1:0] text_color_reg;
    logic              m_valid_reg;
    logic [POS_W-1:0]  m_pos_reg;
    logic [CELL_W-1:0] m_cell_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;
    res_t              res;
    logic              res_ready;

    assign cfg_ready = 1'b1;
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg <= COLOR_RESET;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                text_color_reg <= cfg_data;
            end
            if (res.valid && res_ready)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid && res_ready)
        begin
            m_pos_reg  <= res.cursor_pos;
            m_cell_reg <= res.cell_data;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_cell_reg, m_pos_reg};

    tcw_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .kind       (s_tuser),
        .char_code  (s_tdata[7:0]),
        .cell_index (s_tdata[18:8]),
        .text_color (text_color_reg),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata),
        .res        (res),
        .res_ready  (res_ready)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

@@ test/tb_text_console_writer.sv @@
`timescale 1ns / 1ps

module tb_text_console_writer;
    import tcw_pkg::*;

    typedef struct {
        logic [POS_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
    } console_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;    // char_code[7:0], cell_index[18:8], zero pad
    logic [1:0]  s_tuser = '0;    // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;         // cursor_pos[10:0], cell_data[26:11], zero pad
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = '0;   // text_color

    text_console_writer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Console model: screen, cursor and current attribute
    logic [CELL_W-1:0] screen_model [CELLS];
    logic [ATTR_W-1:0] color_model;
    int                cur_col;
    int                cur_row;

    console_result_t   pending_results [$];

    int tx_idle_pct = 7;
    int rx_idle_pct = 66;
    int stall_req = 0;
    int stall_left = 0;
    int mismatches = 0;
    int n_put = 0;
    int n_clear = 0;
    int n_read = 0;
    int n_none = 0;
    int n_scroll = 0;
    int n_color = 0;

    function automatic void blank_cells(int from, int count);
        for (int i = from; i < from + count; i++)
            screen_model[i] = {color_model, CH_BLANK};
    endfunction

    function automatic void advance_console(logic [CHAR_W-1:0] ch);
        case (ch)
            CH_LF:
            begin
                cur_col = 0;
                cur_row++;
            end
            CH_CR:
                cur_col = 0;
            CH_TAB:
                cur_col = (cur_col + TAB_STEP) & ~(TAB_STEP - 1);
            CH_BS:
            begin
                if (cur_col > 0)
                begin
                    cur_col--;
                    screen_model[cur_row * COLUMNS + cur_col] = {color_model, CH_BLANK};
                end
            end
            default:
            begin
                screen_model[cur_row * COLUMNS + cur_col] = {color_model, ch};
                cur_col++;
            end
        endcase
        if (cur_col >= COLUMNS)
        begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= ROWS)
        begin
            // shift every row up one, blank the bottom row
            for (int i = 0; i < CELLS - COLUMNS; i++)
                screen_model[i] = screen_model[i + COLUMNS];
            blank_cells(CELLS - COLUMNS, COLUMNS);
            cur_row = ROWS - 1;
            n_scroll++;
        end
    endfunction

    function automatic console_result_t predict_console(kind_t kind, logic [CHAR_W-1:0] ch,
                                                        logic [IDX_W-1:0] idx);
        console_result_t r;
        int              pos;
        r.cell_data = '0;
        case (kind)
            KIND_PUT:
            begin
                advance_console(ch);
                n_put++;
            end
            KIND_CLEAR:
            begin
                blank_cells(0, CELLS);
                cur_col = 0;
                cur_row = 0;
                n_clear++;
            end
            KIND_READ:
            begin
                if (idx < CELLS)
                    r.cell_data = screen_model[idx];
                n_read++;
            end
            default:
                n_none++;
        endcase
        pos = cur_row * COLUMNS + cur_col;
        r.cursor_pos = pos[POS_W-1:0];
        return r;
    endfunction

    // Called at a falling edge; returns at a falling edge with tvalid still high
    task automatic send_request(kind_t kind, logic [CHAR_W-1:0] ch, logic [IDX_W-1:0] idx);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'b0, idx, ch};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_console(kind, ch, idx));
        @(negedge clk);
    endtask

    task automatic stop_and_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_color(logic [ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        color_model = value;
        n_color++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: random idling, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (stall_req > 0)
        begin
            stall_left = stall_req;
            stall_req = 0;
        end
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    task automatic report_mismatch(string field, int unsigned expv, int unsigned gotv);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, expv, gotv);
    endtask

    always @(posedge clk)
    begin
        console_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result, cursor_pos", 0, m_tdata[10:0]);
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[10:0] !== want.cursor_pos)
                    report_mismatch("cursor_pos", want.cursor_pos, m_tdata[10:0]);
                if (m_tdata[26:11] !== want.cell_data)
                    report_mismatch("cell_data", want.cell_data, m_tdata[26:11]);
            end
        end
    end

    task automatic test_reset_screen();
        send_request(KIND_READ, 8'h00, 11'd0);
        send_request(KIND_READ, 8'hFF, 11'd1999);
    endtask

    task automatic test_control_codes();
        send_request(KIND_PUT, 8'h00, 11'd0);
        send_request(KIND_PUT, 8'hFF, 11'h7FF);
        send_request(KIND_READ, 8'h00, 11'd1);
        send_request(KIND_PUT, CH_BS, 11'd0);
        send_request(KIND_READ, 8'h00, 11'd1);
        send_request(KIND_PUT, CH_BS, 11'd0);
        // column zero: nothing moves
        send_request(KIND_PUT, CH_BS, 11'd0);
        send_request(KIND_PUT, CH_LF, 11'd0);
        send_request(KIND_PUT, CH_CR, 11'd0);
        send_request(KIND_NONE, 8'hFF, 11'h7FF);
        send_request(KIND_READ, 8'h00, 11'd2000);
        send_request(KIND_READ, 8'h00, 11'h7FF);
        send_request(KIND_CLEAR, 8'hFF, 11'h7FF);
    endtask

    task automatic test_tab_wrap();
        // 20 tabs from column zero: the last one runs off the row end
        for (int i = 0; i < COLUMNS / TAB_STEP; i++)
            send_request(KIND_PUT, CH_TAB, 11'd0);
        send_request(KIND_READ, 8'h00, 11'd0);
    endtask

    task automatic test_random_text(int count, logic [ATTR_W-1:0] color, int tx_pct, int rx_pct);
        int               r;
        int               cur;
        int               back;
        logic [IDX_W-1:0] idx;
        stop_and_drain();
        write_color(color);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 55)
                send_request(KIND_PUT, CHAR_W'($urandom_range(8'h20, 8'h7E)),
                             IDX_W'($urandom_range(2047)));
            else if (r < 62)
                send_request(KIND_PUT, CH_LF, 11'd0);
            else if (r < 65)
                send_request(KIND_PUT, CH_CR, 11'd0);
            else if (r < 70)
                send_request(KIND_PUT, CH_TAB, 11'd0);
            else if (r < 75)
                send_request(KIND_PUT, CH_BS, 11'd0);
            else if (r < 87)
            begin
                // read back recently written text
                cur = cur_row * COLUMNS + cur_col;
                back = $urandom_range(200);
                idx = (cur >= back) ? IDX_W'(cur - back) : IDX_W'($urandom_range(CELLS - 1));
                send_request(KIND_READ, CHAR_W'($urandom_range(255)), idx);
            end
            else if (r < 91)
                send_request(KIND_READ, CHAR_W'($urandom_range(255)),
                             IDX_W'($urandom_range(2047)));
            else if (r < 96)
                send_request(KIND_PUT, CHAR_W'($urandom_range(255)),
                             IDX_W'($urandom_range(2047)));
            else if (r < 98)
                send_request(KIND_NONE, CHAR_W'($urandom_range(255)),
                             IDX_W'($urandom_range(2047)));
            else
                send_request(KIND_CLEAR, CHAR_W'($urandom_range(255)),
                             IDX_W'($urandom_range(2047)));
        end
    endtask

    task automatic test_output_stall();
        stop_and_drain();
        write_color(ATTR_W'($urandom_range(1, 254)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        stall_req = 400;
        for (int n = 0; n < 30; n++)
        begin
            if (n % 3 == 2)
                send_request(KIND_READ, 8'h00, IDX_W'($urandom_range(CELLS - 1)));
            else
                send_request(KIND_PUT, CHAR_W'($urandom_range(8'h20, 8'h7E)), 11'd0);
        end
    endtask

    initial
    begin
        color_model = COLOR_RESET;
        blank_cells(0, CELLS);
        cur_col = 0;
        cur_row = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_screen();
        test_control_codes();
        test_tab_wrap();
        test_random_text(470, 8'h00, 7, 66);
        test_random_text(470, 8'hFF, 66, 7);
        test_random_text(470, ATTR_W'($urandom_range(255)), 0, 0);
        test_output_stall();

        stop_and_drain();
        repeat (10) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("missing results", 0, pending_results.size());

        $display("covered %0d puts, %0d clears, %0d reads, %0d unused kinds, %0d scrolls",
                 n_put, n_clear, n_read, n_none, n_scroll);
        $display("across %0d text_color settings, with random and long output stalls",
                 n_color + 1);
        if (mismatches == 0)
            $display("tb_text_console_writer: done, clean");
        else
            $display("tb_text_console_writer: done, errors");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout waiting for the console");
        $display("tb_text_console_writer: done, errors");
        $finish;
    end

endmodule
